// ----- rtl/core/poc_pkg.sv -----
// Shared types and constants of the prefix order crossover block.
package poc_pkg;

	// Field widths
	localparam int NODE_W = 10;
	localparam int CNT_W  = 11;

	// Bitmap depth default and epoch tag width of the visited memory
	localparam int MAX_NODES_DEF = 1024;
	localparam int EPOCH_W       = 8;

	// Tour size after reset and its third
	localparam int TOUR_RESET = 16;
	localparam int THIRD_RESET = TOUR_RESET / 3;

	// floor(n/3) as (n * 683) >> 11, exact for every 11-bit n
	localparam int THIRD_MUL   = 683;
	localparam int THIRD_SHIFT = 11;
	localparam int THIRD_PW    = CNT_W + 10;

	typedef logic [CNT_W-1:0]   cnt_t;
	typedef logic [NODE_W-1:0]  node_t;
	typedef logic [EPOCH_W-1:0] epoch_t;

	typedef struct packed {
		logic  op;
		node_t node_index;
	} in_item_t;

	typedef struct packed {
		node_t child_node;
		logic  last_of_child;
	} out_item_t;

	// Parent codes carried in op
	localparam logic OP_PARENT_A = 1'b0;
	localparam logic OP_PARENT_B = 1'b1;

endpackage

// ----- rtl/core/poc_tag_ram.sv -----
// Single-port-write, single-port-read tag memory with registered read data.
module poc_tag_ram #(
	parameter int DEPTH  = poc_pkg::MAX_NODES_DEF,
	parameter int ADDR_W = $clog2(DEPTH),
	parameter int DATA_W = poc_pkg::EPOCH_W
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, old data on a same-edge write
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/core/prefix_order_crossover.sv -----
// Top level of the prefix order crossover: child tour from two parent tours.
//
// Usage: parent A's nodes stream in with op = parent A, then parent B's with
// op = parent B, one transfer per cycle while in_stall is low, on the input
// channel (in_valid, in_stall, in_data). The child tour leaves on the output
// channel (out_valid, out_stall, out_data); its final node carries last_of_child.
// tour_size is written through cfg_we / cfg_wdata while the block is idle.
// Pipeline: an input transfer enters the read stage, then the output register.
// Throughput: one item per cycle while no stall or sweep holds the input, set by
// the one read-modify-write of the visited memory per item; a same-node write of
// the item just before is forwarded. Each entry holds an epoch tag, so starting a
// new child costs nothing; once every 2^EPOCH_W-1 children the epoch wraps and a
// sweep of all MAX_NODES entries rewrites the tags, with the input held off.
// Reset: counters clear, tour_size returns to 16, and a sweep of all MAX_NODES
// entries clears the memory before the first input transfer is taken.
// Receiver stall: the output register holds; an item already in the read
// stage waits, and the input stalls only while that stage is occupied.
module prefix_order_crossover #(
	parameter int MAX_NODES = poc_pkg::MAX_NODES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  poc_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output poc_pkg::out_item_t  out_data,
	input  logic                cfg_we,
	input  poc_pkg::cnt_t       cfg_wdata
);

	localparam int ADDR_W = $clog2(MAX_NODES);
	localparam poc_pkg::epoch_t EPOCH_MAX = '1;
	localparam poc_pkg::epoch_t EPOCH_FIRST = poc_pkg::epoch_t'(1);

	// configuration
	poc_pkg::cnt_t tour_q;
	poc_pkg::cnt_t third_q;
	logic [poc_pkg::THIRD_PW-1:0] third_prod;

	// counters and epoch
	poc_pkg::cnt_t   fcnt_q, scnt_q, ecnt_q;
	poc_pkg::epoch_t epoch_q;
	logic            clearing_q;
	logic [ADDR_W-1:0] clr_addr_q;

	// read stage
	logic              valid_s1;
	poc_pkg::in_item_t item_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic              range_s1;

	// forwarding of the last mark
	logic              fwd_valid_q;
	logic [ADDR_W-1:0] fwd_addr_q;

	// memory ports
	logic                 mem_we, mem_re;
	logic [ADDR_W-1:0]    mem_waddr, in_addr;
	poc_pkg::epoch_t      mem_wdata, mem_rdata;

	// decode of the read stage
	logic          in_fire, s1_fire, out_blocked, wrap_hit;
	logic          visited, a_live, b_live, emit, final_item, mark_en, flag;
	poc_pkg::cnt_t scnt_nxt, ecnt_nxt;

	poc_tag_ram #(
		.DEPTH  (MAX_NODES),
		.ADDR_W (ADDR_W),
		.DATA_W (poc_pkg::EPOCH_W)
	) u_tag_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (in_addr),
		.rdata (mem_rdata)
	);

	// floor(n/3) by reciprocal multiply
	assign third_prod = poc_pkg::THIRD_PW'(cfg_wdata) * poc_pkg::THIRD_PW'(poc_pkg::THIRD_MUL);

	// decision for the item in the read stage
	always_comb begin
		visited    = range_s1 && ((mem_rdata == epoch_q) ||
			(fwd_valid_q && (fwd_addr_q == addr_s1)));
		scnt_nxt   = poc_pkg::cnt_t'(scnt_q + 1'b1);
		ecnt_nxt   = poc_pkg::cnt_t'(ecnt_q + 1'b1);
		a_live     = (item_s1.op == poc_pkg::OP_PARENT_A) && (scnt_q == '0) &&
			(fcnt_q < tour_q);
		b_live     = (item_s1.op == poc_pkg::OP_PARENT_B) && (scnt_q < tour_q);
		final_item = b_live && (scnt_nxt == tour_q);
		emit       = (a_live && (fcnt_q < third_q) && (ecnt_q < tour_q)) ||
			(b_live && (ecnt_q < tour_q) && !visited);
		mark_en    = emit && range_s1;
		flag       = (ecnt_nxt == tour_q) || final_item;
	end

	// handshakes
	assign out_blocked = out_valid && out_stall;
	assign s1_fire     = valid_s1 && !out_blocked;
	assign wrap_hit    = final_item && (epoch_q == EPOCH_MAX);
	assign in_stall    = clearing_q || (valid_s1 && (out_blocked || wrap_hit));
	assign in_fire     = in_valid && !in_stall;

	// memory access: read at input transfer; write by the sweep or a mark from the read stage
	assign in_addr   = ADDR_W'(in_data.node_index);
	assign mem_re    = in_fire;
	assign mem_we    = clearing_q || (s1_fire && mark_en);
	assign mem_waddr = clearing_q ? clr_addr_q : addr_s1;
	assign mem_wdata = clearing_q ? '0 : epoch_q;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tour_q      <= poc_pkg::cnt_t'(poc_pkg::TOUR_RESET);
			third_q     <= poc_pkg::cnt_t'(poc_pkg::THIRD_RESET);
			fcnt_q      <= '0;
			scnt_q      <= '0;
			ecnt_q      <= '0;
			epoch_q     <= EPOCH_FIRST;
			clearing_q  <= 1'b1;
			clr_addr_q  <= '0;
			valid_s1    <= 1'b0;
			fwd_valid_q <= 1'b0;
			out_valid   <= 1'b0;
		end else begin
			if (cfg_we) begin
				tour_q  <= cfg_wdata;
				third_q <= poc_pkg::cnt_t'(third_prod[poc_pkg::THIRD_PW-1:poc_pkg::THIRD_SHIFT]);
			end

			// tag sweep
			if (clearing_q) begin
				clr_addr_q <= ADDR_W'(clr_addr_q + 1'b1);
				if (clr_addr_q == ADDR_W'(MAX_NODES - 1)) begin
					clearing_q <= 1'b0;
				end
			end

			// read stage occupancy
			if (in_fire) begin
				valid_s1 <= 1'b1;
			end else if (s1_fire) begin
				valid_s1 <= 1'b0;
			end

			// output register
			if (s1_fire) begin
				out_valid <= emit;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end

			// counters, epoch and forwarding
			if (s1_fire) begin
				if (mark_en) begin
					fwd_valid_q <= 1'b1;
				end
				if (emit) begin
					ecnt_q <= ecnt_nxt;
				end
				if (a_live) begin
					fcnt_q <= poc_pkg::cnt_t'(fcnt_q + 1'b1);
				end
				if (b_live) begin
					scnt_q <= scnt_nxt;
				end
				if (final_item) begin
					fcnt_q      <= '0;
					scnt_q      <= '0;
					ecnt_q      <= '0;
					fwd_valid_q <= 1'b0;
					if (wrap_hit) begin
						epoch_q    <= EPOCH_FIRST;
						clearing_q <= 1'b1;
						clr_addr_q <= '0;
					end else begin
						epoch_q <= poc_pkg::epoch_t'(epoch_q + 1'b1);
					end
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1  <= in_data;
			addr_s1  <= in_addr;
			range_s1 <= (32'(in_data.node_index) < MAX_NODES);
		end
		if (s1_fire && mark_en) begin
			fwd_addr_q <= addr_s1;
		end
		if (s1_fire && emit) begin
			out_data.child_node    <= item_s1.node_index;
			out_data.last_of_child <= flag;
		end
	end

endmodule
